/* rtl/dd_odo_pkg.sv */
package dd_odo_pkg;

  // Default configuration
  localparam int ANGLE_BITS_DEF      = 32;
  localparam int POSITION_BITS_DEF   = 32;
  localparam int TRIG_ITERATIONS_DEF = 16;

  // Arithmetic constants
  localparam int                 ATAN_ENTRIES = 24;
  localparam int                 ITER_W       = 5;
  localparam logic [30:0]        INV_PI_Q32   = 31'd1367130551;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic [15:0]        QUAT_ONE     = 16'd16384;

  typedef struct packed {
    logic        [15:0] time_step;
    logic signed [15:0] unit_a_yaw_rate;
    logic signed [15:0] unit_b_yaw_rate;
    logic signed [15:0] unit_a_pitch_rate;
    logic signed [15:0] unit_b_pitch_rate;
    logic signed [15:0] unit_a_roll_rate;
    logic signed [15:0] unit_b_roll_rate;
    logic signed [15:0] unit_a_left_speed;
    logic signed [15:0] unit_b_left_speed;
    logic signed [15:0] unit_a_right_speed;
    logic signed [15:0] unit_b_right_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] heading_angle;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] velocity_x;
    logic signed [15:0] mean_yaw_rate;
    logic signed [15:0] mean_pitch_rate;
    logic signed [15:0] mean_roll_rate;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_DH,
    ST_HEAD1,
    ST_CINIT1,
    ST_CORD1,
    ST_MUL_PC,
    ST_MUL_PS,
    ST_MUL_XLO,
    ST_MUL_XHI,
    ST_MUL_YLO,
    ST_MUL_YHI,
    ST_UPDATE,
    ST_CINIT2,
    ST_CORD2,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_P,
    OP_MUL_DH,
    OP_HEAD1,
    OP_CINIT1,
    OP_CITER,
    OP_MUL_PC,
    OP_MUL_PS,
    OP_MUL_XLO,
    OP_MUL_XHI,
    OP_MUL_YLO,
    OP_MUL_YHI,
    OP_UPDATE,
    OP_CINIT2,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [ITER_W-1:0] iter;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  // atan(2^-i) as a binary angle, 2^31 = pi
  function automatic logic [29:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Q1.30 to Q1.14, rounded half away from zero, clamped to +-1.0
  function automatic logic [15:0] quat_q(input logic signed [33:0] v);
    logic [33:0] mag;
    logic [33:0] sum;
    logic [17:0] q;
    logic [15:0] qc;
    mag = v[33] ? 34'(-v) : 34'(v);
    sum = mag + 34'd32768;
    q   = sum[33:16];
    qc  = (q > 18'(QUAT_ONE)) ? QUAT_ONE : q[15:0];
    return v[33] ? 16'(-qc) : qc;
  endfunction

endpackage

/* rtl/dd_odo_if.sv */
interface dd_odo_in_if;
  import dd_odo_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dd_odo_out_if;
  import dd_odo_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/dd_odo_ctrl.sv */
module dd_odo_ctrl
  import dd_odo_pkg::*;
#(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(TRIG_ITERATIONS - 1);

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              last_iter;

  assign last_iter = (iter_r == LAST_ITER);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_MUL_P;
      ST_MUL_P:   state_nxt = ST_MUL_DH;
      ST_MUL_DH:  state_nxt = ST_HEAD1;
      ST_HEAD1:   state_nxt = ST_CINIT1;
      ST_CINIT1: begin
        state_nxt = ST_CORD1;
        iter_nxt  = '0;
      end
      ST_CORD1: begin
        iter_nxt = iter_r + 1'b1;
        if (last_iter) state_nxt = ST_MUL_PC;
      end
      ST_MUL_PC:  state_nxt = ST_MUL_PS;
      ST_MUL_PS:  state_nxt = ST_MUL_XLO;
      ST_MUL_XLO: state_nxt = ST_MUL_XHI;
      ST_MUL_XHI: state_nxt = ST_MUL_YLO;
      ST_MUL_YLO: state_nxt = ST_MUL_YHI;
      ST_MUL_YHI: state_nxt = ST_UPDATE;
      ST_UPDATE:  state_nxt = ST_CINIT2;
      ST_CINIT2: begin
        state_nxt = ST_CORD2;
        iter_nxt  = '0;
      end
      ST_CORD2: begin
        iter_nxt = iter_r + 1'b1;
        if (last_iter) state_nxt = ST_FINISH;
      end
      ST_FINISH:  if (!stat.out_busy) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    cmd.iter = iter_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_MUL_P:   cmd.op = OP_MUL_P;
      ST_MUL_DH:  cmd.op = OP_MUL_DH;
      ST_HEAD1:   cmd.op = OP_HEAD1;
      ST_CINIT1:  cmd.op = OP_CINIT1;
      ST_CORD1:   cmd.op = OP_CITER;
      ST_MUL_PC:  cmd.op = OP_MUL_PC;
      ST_MUL_PS:  cmd.op = OP_MUL_PS;
      ST_MUL_XLO: cmd.op = OP_MUL_XLO;
      ST_MUL_XHI: cmd.op = OP_MUL_XHI;
      ST_MUL_YLO: cmd.op = OP_MUL_YLO;
      ST_MUL_YHI: cmd.op = OP_MUL_YHI;
      ST_UPDATE:  cmd.op = OP_UPDATE;
      ST_CINIT2:  cmd.op = OP_CINIT2;
      ST_CORD2:   cmd.op = OP_CITER;
      ST_FINISH:  if (!stat.out_busy) cmd.op = OP_OUT;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

/* rtl/dd_odo_dp.sv */
module dd_odo_dp
  import dd_odo_pkg::*;
#(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  in_item_t  in_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  output dp_stat_t  stat
);

  localparam int AB = ANGLE_BITS;
  localparam int PB = POSITION_BITS;
  localparam int SH = 63 - AB;
  localparam int PW = (PB > 32) ? PB : 32;

  in_item_t               in_r;
  logic        [AB-1:0]   heading_r;
  logic        [AB-1:0]   dh_r;
  logic signed [PB-1:0]   posx_r, posy_r;
  logic        [31:0]     pmag_r;
  logic        [62:0]     dhprod_r;
  logic        [63:0]     pc_r, ps_r, qx_r, qy_r;
  logic                   sgn_x_r, sgn_y_r;
  logic signed [33:0]     cx_r, cy_r, cz_r;
  logic                   flip_r;
  logic signed [15:0]     vx_r;
  out_item_t              out_r;
  logic                   out_valid_r;

  // sample decode
  logic signed [16:0] yaw_sum, pitch_sum, roll_sum;
  logic signed [17:0] yaw2, spd;
  logic signed [16:0] yaw_half;
  logic        [16:0] yaw_mag;
  logic        [17:0] spd_mag;
  logic        [15:0] yaw_out;

  assign yaw_sum   = 17'(in_r.unit_a_yaw_rate) + 17'(in_r.unit_b_yaw_rate);
  assign pitch_sum = 17'(in_r.unit_a_pitch_rate) + 17'(in_r.unit_b_pitch_rate);
  assign roll_sum  = 17'(in_r.unit_a_roll_rate) + 17'(in_r.unit_b_roll_rate);
  assign yaw2      = -18'(yaw_sum);
  assign yaw_mag   = yaw2[17] ? 17'(-yaw2) : 17'(yaw2);
  assign spd       = 18'(in_r.unit_a_left_speed) + 18'(in_r.unit_b_left_speed)
                   + 18'(in_r.unit_a_right_speed) + 18'(in_r.unit_b_right_speed);
  assign spd_mag   = spd[17] ? 18'(-spd) : 18'(spd);
  assign yaw_half  = yaw2[17:1];
  // both yaw rates at the negative limit give a negated mean of +32768
  assign yaw_out   = (!yaw_half[16] && yaw_half[15]) ? 16'h7fff : yaw_half[15:0];

  // top 32 bits of the heading
  logic [31:0] ang32;
  generate
    if (AB >= 32) begin : g_ang_wide
      assign ang32 = heading_r[AB-1 -: 32];
    end else begin : g_ang_narrow
      assign ang32 = {heading_r, {(32 - AB){1'b0}}};
    end
  endgenerate

  // trig results with the half-turn fold undone
  logic signed [33:0] trig_c, trig_s;
  logic        [33:0] trig_c_mag, trig_s_mag;
  assign trig_c     = flip_r ? -cx_r : cx_r;
  assign trig_s     = flip_r ? -cy_r : cy_r;
  assign trig_c_mag = trig_c[33] ? 34'(-trig_c) : 34'(trig_c);
  assign trig_s_mag = trig_s[33] ? 34'(-trig_s) : 34'(trig_s);

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_P: begin
        mul_a = 32'(yaw_mag);
        mul_b = 32'(in_r.time_step);
      end
      OP_MUL_DH: begin
        mul_a = pmag_r;
        mul_b = 32'(INV_PI_Q32);
      end
      OP_MUL_PC: begin
        mul_a = 32'(spd_mag);
        mul_b = trig_c_mag[31:0];
      end
      OP_MUL_PS: begin
        mul_a = 32'(spd_mag);
        mul_b = trig_s_mag[31:0];
      end
      OP_MUL_XLO: begin
        mul_a = pc_r[31:0];
        mul_b = 32'(in_r.time_step);
      end
      OP_MUL_XHI: begin
        mul_a = pc_r[63:32];
        mul_b = 32'(in_r.time_step);
      end
      OP_MUL_YLO: begin
        mul_a = ps_r[31:0];
        mul_b = 32'(in_r.time_step);
      end
      OP_MUL_YHI: begin
        mul_a = ps_r[63:32];
        mul_b = 32'(in_r.time_step);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // half-step heading increment, rounded half away from zero
  logic [63:0]   dh_sum;
  logic [AB-1:0] dh_q, dh_val;
  assign dh_sum = {1'b0, dhprod_r} + (64'd1 << (SH - 1));
  assign dh_q   = dh_sum[SH +: AB];
  assign dh_val = yaw2[17] ? AB'(-dh_q) : dh_q;

  // CORDIC start vector
  logic [31:0]        csrc;
  logic               cflip;
  logic signed [31:0] cz0;
  assign csrc  = (cmd.op == OP_CINIT2) ? {ang32[31], ang32[31:1]} : ang32;
  assign cflip = csrc[31] ^ csrc[30];
  assign cz0   = {csrc[31] ^ cflip, csrc[30:0]};

  // CORDIC micro-rotation
  logic signed [33:0] cxs, cys, cat;
  assign cxs = cx_r >>> cmd.iter;
  assign cys = cy_r >>> cmd.iter;
  assign cat = 34'(atan_lut(cmd.iter));

  // position steps and velocity
  logic [63:0]          qx_sum, qy_sum, v_sum;
  logic signed [PB:0]   dx, dy, sumx, sumy;
  logic signed [PB-1:0] posx_nxt, posy_nxt;
  logic [31:0]          vq;
  logic signed [15:0]   vx_nxt;

  assign qx_sum = qx_r + (64'd1 << 41);
  assign qy_sum = qy_r + (64'd1 << 41);
  assign dx     = sgn_x_r ? -(PB+1)'(qx_sum[63:42]) : (PB+1)'(qx_sum[63:42]);
  assign dy     = sgn_y_r ? -(PB+1)'(qy_sum[63:42]) : (PB+1)'(qy_sum[63:42]);
  assign sumx   = (PB+1)'(posx_r) + dx;
  assign sumy   = (PB+1)'(posy_r) + dy;

  always_comb begin
    if (sumx[PB] != sumx[PB-1])
      posx_nxt = sumx[PB] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
    else
      posx_nxt = sumx[PB-1:0];
    if (sumy[PB] != sumy[PB-1])
      posy_nxt = sumy[PB] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
    else
      posy_nxt = sumy[PB-1:0];
  end

  assign v_sum = pc_r + (64'd1 << 31);
  assign vq    = v_sum[63:32];
  always_comb begin
    if (sgn_x_r)
      vx_nxt = (vq > 32'd32768) ? 16'sh8000 : 16'(-vq[15:0]);
    else
      vx_nxt = (vq > 32'd32767) ? 16'sh7fff : vq[15:0];
  end

  // 32-bit view of the position accumulators
  logic signed [PW-1:0] px_ext, py_ext;
  logic        [31:0]   px_out, py_out;
  assign px_ext = PW'(posx_r);
  assign py_ext = PW'(posy_r);
  assign px_out = (&px_ext[PW-1:31] || ~|px_ext[PW-1:31]) ? px_ext[31:0]
                : (px_ext[PW-1] ? 32'h8000_0000 : 32'h7fff_ffff);
  assign py_out = (&py_ext[PW-1:31] || ~|py_ext[PW-1:31]) ? py_ext[31:0]
                : (py_ext[PW-1] ? 32'h8000_0000 : 32'h7fff_ffff);

  // pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r <= '0;
      posx_r    <= '0;
      posy_r    <= '0;
    end else begin
      if (cmd.op == OP_HEAD1) heading_r <= heading_r + dh_val;
      if (cmd.op == OP_UPDATE) begin
        heading_r <= heading_r + dh_r;
        posx_r    <= posx_nxt;
        posy_r    <= posy_nxt;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:    in_r <= in_data;
      OP_MUL_P:   pmag_r <= mul_p[31:0];
      OP_MUL_DH:  dhprod_r <= mul_p[62:0];
      OP_HEAD1:   dh_r <= dh_val;
      OP_CINIT1, OP_CINIT2: begin
        cx_r   <= CORDIC_START;
        cy_r   <= '0;
        cz_r   <= 34'(cz0);
        flip_r <= cflip;
      end
      OP_CITER: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - cys;
          cy_r <= cy_r + cxs;
          cz_r <= cz_r - cat;
        end else begin
          cx_r <= cx_r + cys;
          cy_r <= cy_r - cxs;
          cz_r <= cz_r + cat;
        end
      end
      OP_MUL_PC: begin
        pc_r    <= mul_p;
        sgn_x_r <= spd[17] ^ trig_c[33];
      end
      OP_MUL_PS: begin
        ps_r    <= mul_p;
        sgn_y_r <= spd[17] ^ trig_s[33];
      end
      OP_MUL_XLO: qx_r <= mul_p;
      OP_MUL_XHI: qx_r <= qx_r + {mul_p[31:0], 32'd0};
      OP_MUL_YLO: qy_r <= mul_p;
      OP_MUL_YHI: qy_r <= qy_r + {mul_p[31:0], 32'd0};
      OP_UPDATE:  vx_r <= vx_nxt;
      OP_OUT: begin
        out_r.position_x      <= px_out;
        out_r.position_y      <= py_out;
        out_r.heading_angle   <= ang32;
        out_r.quat_z          <= quat_q(trig_s);
        out_r.quat_w          <= quat_q(trig_c);
        out_r.velocity_x      <= vx_r;
        out_r.mean_yaw_rate   <= yaw_out;
        out_r.mean_pitch_rate <= pitch_sum[16:1];
        out_r.mean_roll_rate  <= roll_sum[16:1];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

/* rtl/diff_drive_odometry_integrator.sv */
// Dead-reckoning odometry for a differential drive with two drive units.
// Each request is one status sample; the block averages the paired rates,
// sums the wheel speeds, advances the heading by half a step, projects the
// summed speed through a CORDIC cos/sin of that heading into saturating x/y
// accumulators, completes the heading step and returns one pose result with
// a Q1.14 yaw quaternion. The work runs through two passes of the single
// shift-add CORDIC unit and eight passes through one shared 32x32 multiplier.
// The result sits in an output register, so the next sample is accepted while
// it waits; a sample finishing before the previous result is taken holds in
// its final state. Heading, x and y clear on reset.
module diff_drive_odometry_integrator
  import dd_odo_pkg::*;
#(
  parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
  parameter int POSITION_BITS   = POSITION_BITS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dd_odo_in_if.sink   in_ch,
  dd_odo_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  dd_odo_ctrl #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // arithmetic and pose state
  dd_odo_dp #(
    .ANGLE_BITS   (ANGLE_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_ch.data),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .out_data (out_ch.data),
    .stat     (stat)
  );

endmodule

/* rtl/dd_odo_chk.sv */
module dd_odo_chk
  import dd_odo_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a taken request keeps the block busy for the following cycles
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("ready returned too soon after a request");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // quaternion terms stay within +-1.0
  a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.quat_z) <= 16384 &&
                   $signed(out_data.quat_z) >= -16384 &&
                   $signed(out_data.quat_w) <= 16384 &&
                   $signed(out_data.quat_w) >= -16384))
    else $error("quaternion out of range");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind diff_drive_odometry_integrator dd_odo_chk u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data (out_ch.data)
);

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import dd_odo_pkg::*;

  localparam int ANG_W   = ANGLE_BITS_DEF;
  localparam int POS_W   = POSITION_BITS_DEF;
  localparam int N_ITER  = TRIG_ITERATIONS_DEF;
  localparam int N_RAND  = 1030;
  localparam int LATENCY = 2 * N_ITER + 13;

  logic clk;
  logic rst_n;

  dd_odo_in_if  in_ch ();
  dd_odo_out_if out_ch ();

  diff_drive_odometry_integrator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state
  logic [63:0]      odo_heading;
  longint           odo_pos_x;
  longint           odo_pos_y;
  out_item_t        pose_q[$];
  int               n_fail;
  bit               sender_done;

  longint           atan_tab[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_away(longint unsigned mag, bit neg, int s);
    longint unsigned q;
    q = (mag + (64'd1 << (s - 1))) >> s;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint top_angle(logic [63:0] a);
    logic [31:0] t;
    if (ANG_W >= 32) t = 32'(a >> (ANG_W - 32));
    else t = 32'(a << (32 - ANG_W));
    return longint'($signed(t));
  endfunction

  // Rotation-mode CORDIC, Q1.30 out
  task automatic sincos(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    bit flip;
    x = longint'(CORDIC_START);
    y = 0;
    z = ang;
    flip = 0;
    if (z >= (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
      z = (z >= 0) ? z - (64'sd1 <<< 31) : z + (64'sd1 <<< 31);
      flip = 1;
    end
    for (int i = 0; i < N_ITER && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        z -= atan_tab[i];
      end else begin
        nx = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        z += atan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint travel(longint spd, longint trig, longint dt);
    longint unsigned m;
    m = mag_of(spd) * mag_of(trig) * longint'(dt);
    return round_away(m, (spd < 0) != (trig < 0), 42);
  endfunction

  function automatic longint acc_add(longint acc, longint d);
    longint hi;
    hi = (64'sd1 <<< (POS_W - 1)) - 1;
    return clamp(acc + d, -hi - 1, hi);
  endfunction

  // Advance the pose for one sample and return the expected result
  task automatic predict_pose(input in_item_t s, output out_item_t r);
    logic [63:0] amask;
    longint dt, yaw2, pitch, roll, spd, p, dh, c, sn, qz, qw, vx;
    amask = (ANG_W >= 64) ? '1 : ((64'd1 << ANG_W) - 1);
    dt    = longint'(s.time_step);
    yaw2  = -(longint'(s.unit_a_yaw_rate) + longint'(s.unit_b_yaw_rate));
    pitch = (longint'(s.unit_a_pitch_rate) + longint'(s.unit_b_pitch_rate)) >>> 1;
    roll  = (longint'(s.unit_a_roll_rate) + longint'(s.unit_b_roll_rate)) >>> 1;
    spd   = longint'(s.unit_a_left_speed) + longint'(s.unit_b_left_speed)
          + longint'(s.unit_a_right_speed) + longint'(s.unit_b_right_speed);
    p     = yaw2 * dt;
    dh    = round_away(mag_of(p) * 64'd1367130551, p < 0, 63 - ANG_W);
    odo_heading = (odo_heading + 64'(dh)) & amask;
    sincos(top_angle(odo_heading), c, sn);
    vx = clamp(round_away(mag_of(spd) * mag_of(c), (spd < 0) != (c < 0), 32),
               -32768, 32767);
    odo_pos_x = acc_add(odo_pos_x, travel(spd, c, dt));
    odo_pos_y = acc_add(odo_pos_y, travel(spd, sn, dt));
    odo_heading = (odo_heading + 64'(dh)) & amask;
    sincos(top_angle(odo_heading) >>> 1, qw, qz);
    qz = clamp(round_away(mag_of(qz), qz < 0, 16), -16384, 16384);
    qw = clamp(round_away(mag_of(qw), qw < 0, 16), -16384, 16384);
    r.position_x      = 32'(clamp(odo_pos_x, -64'sd2147483648, 64'sd2147483647));
    r.position_y      = 32'(clamp(odo_pos_y, -64'sd2147483648, 64'sd2147483647));
    r.heading_angle   = 32'(top_angle(odo_heading));
    r.quat_z          = 16'(qz);
    r.quat_w          = 16'(qw);
    r.velocity_x      = 16'(vx);
    r.mean_yaw_rate   = 16'(clamp(yaw2 >>> 1, -32768, 32767));
    r.mean_pitch_rate = 16'(pitch);
    r.mean_roll_rate  = 16'(roll);
  endtask

  // Directed table; fixed rows carry a typed-in expectation
  typedef struct {
    in_item_t  smp;
    bit        fixed;
    out_item_t want;
  } row_t;

  row_t rows[$];

  function automatic in_item_t mk(logic [15:0] dt, logic [15:0] ya, logic [15:0] yb,
                                  logic [15:0] pa, logic [15:0] pb, logic [15:0] ra,
                                  logic [15:0] rb, logic [15:0] spd);
    in_item_t s;
    s = '{dt, ya, yb, pa, pb, ra, rb, spd, spd, spd, spd};
    return s;
  endfunction

  function automatic in_item_t rand_sample(int kind);
    in_item_t     s;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    s = raw[175:0];
    case (kind)
      0: begin
        // gentle drive: small yaw rates, modest step
        s.time_step = 16'($urandom_range(0, 8000));
        s.unit_a_yaw_rate = 16'($signed(16'($urandom_range(0, 8000)) - 16'd4000));
        s.unit_b_yaw_rate = s.unit_a_yaw_rate + 16'($urandom_range(0, 15));
      end
      1: s.time_step = (s.time_step[0]) ? 16'hFFFF : 16'h0000;
      default: ;
    endcase
    return s;
  endfunction

  task automatic build_table();
    row_t r;
    // zero step, zero everything: pose stays at origin, unit quaternion
    r.smp = mk(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    r.fixed = 1;
    r.want = '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0,
               16'sd0, 16'sd0};
    rows.push_back(r);
    // yaw mean overflow on a zero step, rate extremes
    r.smp = mk(16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd0);
    r.want = '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd32767,
               -16'sd32768, 16'sd32767};
    rows.push_back(r);
    r.fixed = 0;
    r.smp = mk(16'd0, 16'h7FFF, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    rows.push_back(r);
    r.smp = mk(16'd0, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
    rows.push_back(r);
    // full-speed straight runs, then big turns and max steps
    for (int i = 0; i < 6; i++) begin
      r.smp = mk(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF);
      rows.push_back(r);
    end
    for (int i = 0; i < 6; i++) begin
      r.smp = mk(16'hFFFF, 16'h8000, 16'h8000, 16'd5, 16'd3, 16'hFFFB, 16'd1, 16'h8000);
      rows.push_back(r);
    end
    for (int i = 0; i < 6; i++) begin
      r.smp = mk(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
      rows.push_back(r);
    end
    r.smp = mk(16'h1234, 16'h0100, 16'hFF00, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0400);
    rows.push_back(r);
  endtask

  // Send one sample; predict it at acceptance
  task automatic send_sample(input in_item_t s, input bit fixed, input out_item_t want);
    out_item_t r;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      // idle the request line for the drawn gap
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_pose(s, r);
    pose_q.push_back(fixed ? want : r);
  endtask

  // Stimulus
  initial begin
    out_item_t none;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    odo_heading  = '0;
    odo_pos_x    = 0;
    odo_pos_y    = 0;
    n_fail       = 0;
    sender_done  = 0;
    none         = '0;
    build_table();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_sample(rows[i].smp, rows[i].fixed, rows[i].want);
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND / 2) begin
        // drain everything before carrying on
        in_ch.valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge clk);
      end
      send_sample(rand_sample($urandom_range(0, 3)), 0, none);
    end
    in_ch.valid <= 1'b0;
    sender_done = 1;
  end

  // Result receiver with random stalls
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      check_pose(out_ch.data);
    end
  end

  task automatic check_pose(input out_item_t got);
    out_item_t exp_r;
    if (pose_q.size() == 0) begin
      n_fail++;
      if (n_fail <= 10) $display("unexpected result %p", got);
      return;
    end
    exp_r = pose_q.pop_front();
    if (got !== exp_r) begin
      n_fail++;
      if (n_fail <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
    end
  endtask

  // End of run
  initial begin
    wait (sender_done);
    while (pose_q.size() != 0) @(posedge clk);
    repeat (LATENCY * 2) @(posedge clk);
    if (n_fail == 0 && pose_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Timeout
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
